/* rtl/slt_pkg.sv */
// Package for the sorted list table: capacity, widths, operation and status
// codes, and the request, result and controller interface structs.
// No dependencies; every other file in the project refers to it.
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int OUT_CNT_W = 5;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_DUMP_FWD = 2'd2;
    localparam logic [1:0] OP_DUMP_BWD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]                 operation;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } t_request;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  item_value;
        logic [1:0]                 status;
        logic [OUT_CNT_W-1:0]       entry_count;
        logic                       last_of_run;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request
        logic exec;       // carry out insert/delete, or start a dump
        logic dump_step;  // emit one entry of a dump
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dump;
        logic is_empty;
        logic dump_last;
    } t_stat;

endpackage

/* rtl/slt_ctrl.sv */
// Controller state machine of the sorted list table.
// Depends on slt_pkg for the command and status structs.
module slt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  slt_pkg::t_stat i_stat,
    output slt_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_dump && !i_stat.is_empty) begin
                    n_state = S_DUMP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                o_cmd.dump_step = 1'b1;
                if (i_stat.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/slt_datapath.sv */
// Datapath of the sorted list table: the row of entry cells, the entry
// count, the dump index and the registered result. Depends on slt_pkg.
module slt_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  slt_pkg::t_request i_req,
    input  slt_pkg::t_cmd     i_cmd,
    output slt_pkg::t_stat    o_stat,
    output slt_pkg::t_result  o_result,
    output logic              o_valid
);

    logic signed [slt_pkg::VALUE_W-1:0] r_entries [slt_pkg::CAPACITY];
    logic signed [slt_pkg::VALUE_W-1:0] n_entries [slt_pkg::CAPACITY];
    logic [slt_pkg::CNT_W-1:0]          r_count;
    logic [slt_pkg::CNT_W-1:0]          n_count;
    logic [slt_pkg::IDX_W-1:0]          r_idx;
    logic [slt_pkg::IDX_W-1:0]          n_idx;
    slt_pkg::t_request                  r_req;
    slt_pkg::t_result                   r_result;
    slt_pkg::t_result                   n_result;
    logic                               r_valid;
    logic                               n_valid;

    logic [slt_pkg::CAPACITY-1:0]       le;
    logic                               is_full;
    logic                               pos_ok;
    logic                               dump_last;
    logic [slt_pkg::IDX_W-1:0]          rd_addr;

    // Cells holding a value not above the new one; a prefix, as the row is sorted.
    always_comb begin
        for (int i = 0; i < slt_pkg::CAPACITY; i++) begin
            le[i] = (slt_pkg::CNT_W'(i) < r_count) && (r_entries[i] <= r_req.value);
        end
    end

    assign is_full   = (r_count >= slt_pkg::CNT_W'(slt_pkg::CAPACITY));
    assign pos_ok    = (r_req.position != '0) &&
                       (r_req.position <= slt_pkg::POS_W'(r_count));
    assign dump_last = (slt_pkg::CNT_W'(r_idx) == (r_count - slt_pkg::CNT_W'(1)));
    assign rd_addr   = (r_req.operation == slt_pkg::OP_DUMP_FWD) ? r_idx :
                       slt_pkg::IDX_W'(r_count - slt_pkg::CNT_W'(1) - slt_pkg::CNT_W'(r_idx));

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_result  = r_result;

        if (i_cmd.exec) begin
            n_result.item_value  = '0;
            n_result.last_of_run = 1'b1;
            n_result.status      = slt_pkg::ST_OK;
            n_idx                = '0;
            case (r_req.operation)
                slt_pkg::OP_INSERT: begin
                    n_valid = 1'b1;
                    if (is_full) begin
                        n_result.status = slt_pkg::ST_FULL;
                    end else begin
                        // Each cell keeps its value, takes the new one, or
                        // takes its lower neighbour's, all in one step.
                        for (int i = 0; i < slt_pkg::CAPACITY; i++) begin
                            if (le[i]) begin
                                n_entries[i] = r_entries[i];
                            end else if (i == 0) begin
                                n_entries[i] = r_req.value;
                            end else if (le[(i == 0) ? 0 : i - 1]) begin
                                n_entries[i] = r_req.value;
                            end else begin
                                n_entries[i] = r_entries[(i == 0) ? 0 : i - 1];
                            end
                        end
                        n_count = r_count + slt_pkg::CNT_W'(1);
                    end
                end
                slt_pkg::OP_DELETE: begin
                    n_valid = 1'b1;
                    if (!pos_ok) begin
                        n_result.status = slt_pkg::ST_RANGE;
                    end else begin
                        // Cells at or above the deleted one take their upper neighbour.
                        for (int i = 0; i < slt_pkg::CAPACITY - 1; i++) begin
                            if (slt_pkg::POS_W'(i + 1) >= r_req.position) begin
                                n_entries[i] = r_entries[i + 1];
                            end
                        end
                        n_count = r_count - slt_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    if (r_count == '0) begin
                        n_valid         = 1'b1;
                        n_result.status = slt_pkg::ST_EMPTY;
                    end
                end
            endcase
            n_result.entry_count = slt_pkg::OUT_CNT_W'(n_count);
        end else if (i_cmd.dump_step) begin
            n_valid              = 1'b1;
            n_result.item_value  = r_entries[rd_addr];
            n_result.status      = slt_pkg::ST_OK;
            n_result.entry_count = slt_pkg::OUT_CNT_W'(r_count);
            n_result.last_of_run = dump_last;
            n_idx                = r_idx + slt_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        r_result  <= n_result;
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    assign o_stat.is_dump   = (r_req.operation == slt_pkg::OP_DUMP_FWD) ||
                              (r_req.operation == slt_pkg::OP_DUMP_BWD);
    assign o_stat.is_empty  = (r_count == '0);
    assign o_stat.dump_last = dump_last;
    assign o_result         = r_result;
    assign o_valid          = r_valid;

endmodule

/* rtl/sorted_list_table.sv */
// Sorted list table top level: a request is taken when start is high and busy low.
// Insert and delete: the request is registered, carried out in the exec state, and one result
// is registered from that. Dump of n entries: busy through the exec state and n dump steps,
// one result per entry read from the cell row on consecutive cycles; an empty dump gives one.
// Results are strobed for one cycle and cannot be held off. Synchronous active-low
// reset empties the table. Depends on slt_pkg, slt_ctrl and slt_datapath.
module sorted_list_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  slt_pkg::t_request i_req,
    output logic              busy,
    output logic              o_valid,
    output slt_pkg::t_result  o_result
);

    slt_pkg::t_cmd  cmd;
    slt_pkg::t_stat stat;

    slt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    slt_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule
